// ----- rtl/chm_pkg.sv -----
// Shared constants, types and the bucket hash of the chained hash map engine.
package chm_pkg;

   localparam int MAX_BUCKETS  = 1024;
   localparam int POOL_ENTRIES = 1024;
   localparam int BKT_W        = $clog2(MAX_BUCKETS);
   localparam int NODE_W       = $clog2(POOL_ENTRIES);
   localparam int PTR_W        = NODE_W + 1;
   localparam int KEY_BYTES    = 16;
   localparam int LEN_W        = 5;
   localparam int VAL_W        = 32;
   localparam int LOG2_W       = 4;

   localparam logic [PTR_W-1:0]  NIL_PTR   = PTR_W'(POOL_ENTRIES);
   localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(KEY_BYTES);
   localparam logic [LOG2_W-1:0] LOG2_RST  = LOG2_W'(10);

   // request codes
   localparam logic [1:0] REQ_BIND    = 2'd0;
   localparam logic [1:0] REQ_RESOLVE = 2'd1;
   localparam logic [1:0] REQ_UNBIND  = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_BOUND = 2'd1;
   localparam logic [1:0] STAT_NOMEM = 2'd2;
   localparam logic [1:0] STAT_MISS  = 2'd3;

   // one pool node as stored in the node memory
   typedef struct packed {
      logic [LEN_W-1:0] key_len;
      logic [63:0]      key_hi;
      logic [63:0]      key_lo;
      logic [VAL_W-1:0] value;
   } node_type;

   // byte-wise shift-add-XOR hash, masked to the bucket count
   function automatic logic [BKT_W-1:0] chm_hash(input logic [127:0] key,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [LOG2_W-1:0] lg);
      logic [11:0] h;
      logic [11:0] b0, b1, b2, b3;
      logic [3:0]  p;
      logic [3:0]  q;
      logic [15:0] mask;
      h = '0;
      for (int g = 0; g < 4; g++) begin
         b0 = {4'b0, key[32*g +: 8]};
         b1 = {4'b0, key[32*g+8 +: 8]};
         b2 = {4'b0, key[32*g+16 +: 8]};
         b3 = {4'b0, key[32*g+24 +: 8]};
         if (3'(g) < len[4:2]) begin
            h = h ^ ((b0 + (b2 << 2)) ^ (b1 + (b3 << 1)) ^ (b2 + (b0 << 1))
                     ^ ((b3 + b1) << 2));
         end
      end
      p  = {len[3:2], 2'b00};
      b0 = {4'b0, key[8*p +: 8]};
      b1 = {4'b0, key[8*(p+4'd1) +: 8]};
      if (len[1]) begin
         h = h ^ (((b0 << 2) + b1) ^ ((b1 << 2) + b0));
      end
      q = len[1] ? p + 4'd2 : p;
      if (len[0]) begin
         h = h ^ {4'b0, key[8*q +: 8]};
      end
      mask = 16'((17'd1 << lg) - 17'd1);
      return BKT_W'({4'b0, h} & mask);
   endfunction

endpackage

// ----- rtl/chm_req_if.sv -----
// Request channel of the hash map engine.
interface chm_req_if;
   import chm_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       req_type;
   logic [63:0]      key_lo;
   logic [63:0]      key_hi;
   logic [LEN_W-1:0] key_len;
   logic [VAL_W-1:0] new_value;
   modport source (output valid, req_type, key_lo, key_hi, key_len, new_value,
                   input ready);
   modport sink   (input valid, req_type, key_lo, key_hi, key_len, new_value,
                   output ready);
endinterface

// ----- rtl/chm_rsp_if.sv -----
// Response channel of the hash map engine.
interface chm_rsp_if;
   import chm_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [VAL_W-1:0] out_value;
   modport source (output valid, status, out_value, input ready);
   modport sink   (input valid, status, out_value, output ready);
endinterface

// ----- rtl/chm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/chained_hash_map_engine.sv -----
// Hash map engine: keys of up to 16 bytes mapped to 32-bit values.
// req_ch carries bind, resolve and unbind requests (valid/ready); rsp_ch
// returns one status/value pair per request in request order. csr_we with
// csr_wdata sets log2 of the bucket count; write it only while idle.
// After reset the engine clears the bucket table and chains the node pool
// into the free list, one entry per cycle, with req_ch.ready held low.
// One request is worked at a time. From accept the engine passes ST_HASH
// and ST_HEAD, then walks the chain with one node memory read per cycle,
// and answers from ST_OUT; a bind that inserts adds ST_ALLOC and ST_LINK,
// an unbind hit ST_UNL. A last-hit cache hit on resolve skips the walk.
// The response sits in an output register; while the receiver stalls it
// holds, and the engine finishes the current request and then waits.
// Requests are taken again as soon as the engine returns to idle.
module chained_hash_map_engine (
   input  logic                      clock,
   input  logic                      reset,
   chm_req_if.sink                   req_ch,
   chm_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [chm_pkg::LOG2_W-1:0] csr_wdata
);
   import chm_pkg::*;

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_HASH  = 4'd2;
   localparam logic [3:0] ST_HEAD  = 4'd3;
   localparam logic [3:0] ST_WALK  = 4'd4;
   localparam logic [3:0] ST_ALLOC = 4'd5;
   localparam logic [3:0] ST_LINK  = 4'd6;
   localparam logic [3:0] ST_UNL   = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [LOG2_W-1:0] log2_ff;
   logic [1:0]        type_ff, type_in;
   node_type          key_ff, key_in;
   logic [BKT_W-1:0]  bkt_ff, bkt_in;
   logic [PTR_W-1:0]  cur_ff, cur_in;
   logic [PTR_W-1:0]  prev_ff, prev_in;
   logic [PTR_W-1:0]  free_ff, free_in;
   logic [PTR_W-1:0]  cache_ff, cache_in;
   logic [1:0]        res_stat_ff, res_stat_in;
   logic [VAL_W-1:0]  res_val_ff, res_val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_stat_ff, rsp_stat_in;
   logic [VAL_W-1:0]  rsp_val_ff, rsp_val_in;

   // memory ports
   logic              head_we;
   logic [BKT_W-1:0]  head_waddr, head_raddr;
   logic [PTR_W-1:0]  head_wdata, head_rdata;
   logic              node_we;
   logic [NODE_W-1:0] node_waddr, node_raddr;
   node_type          node_wdata, node_rdata;
   logic              link_we;
   logic [NODE_W-1:0] link_waddr;
   logic [PTR_W-1:0]  link_wdata, link_rdata;

   logic              accept;
   logic [LEN_W-1:0]  len_sat;
   logic [127:0]      key_raw, key_norm;
   logic              node_hit;
   logic [BKT_W-1:0]  hash;

   chm_ram #(.WIDTH(PTR_W), .DEPTH(MAX_BUCKETS)) u_head (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_rdata));

   chm_ram #(.WIDTH($bits(node_type)), .DEPTH(POOL_ENTRIES)) u_node (
      .clock(clock), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
      .raddr(node_raddr), .rdata(node_rdata));

   chm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_link (
      .clock(clock), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .raddr(node_raddr), .rdata(link_rdata));

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign accept           = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_stat_ff;
   assign rsp_ch.out_value = rsp_val_ff;

   // saturate the length and zero the bytes past it
   always_comb begin
      len_sat = (req_ch.key_len > MAX_LEN) ? MAX_LEN : req_ch.key_len;
      key_raw = {req_ch.key_hi, req_ch.key_lo};
      for (int i = 0; i < KEY_BYTES; i++) begin
         key_norm[8*i +: 8] = (LEN_W'(i) < len_sat) ? key_raw[8*i +: 8] : 8'h00;
      end
   end

   assign hash     = chm_hash({key_ff.key_hi, key_ff.key_lo}, key_ff.key_len, log2_ff);
   assign node_hit = (node_rdata.key_len == key_ff.key_len) &&
                     (node_rdata.key_lo == key_ff.key_lo) &&
                     (node_rdata.key_hi == key_ff.key_hi);

   // sequencer: hash, head read, chain walk, then modify and write back
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      type_in     = type_ff;
      key_in      = key_ff;
      bkt_in      = bkt_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      free_in     = free_ff;
      cache_in    = cache_ff;
      res_stat_in = res_stat_ff;
      res_val_in  = res_val_ff;
      head_we     = 1'b0;
      head_waddr  = bkt_ff;
      head_wdata  = NIL_PTR;
      head_raddr  = hash;
      node_we     = 1'b0;
      node_waddr  = free_ff[NODE_W-1:0];
      node_wdata  = key_ff;
      node_raddr  = cur_ff[NODE_W-1:0];
      link_we     = 1'b0;
      link_waddr  = prev_ff[NODE_W-1:0];
      link_wdata  = NIL_PTR;
      unique case (state_ff)
         ST_CLR: begin
            head_we    = 1'b1;
            head_waddr = BKT_W'(clr_ff);
            link_we    = 1'b1;
            link_waddr = clr_ff;
            link_wdata = PTR_W'(clr_ff) + PTR_W'(1);
            clr_in     = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(POOL_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               type_in        = req_ch.req_type;
               key_in.key_lo  = key_norm[63:0];
               key_in.key_hi  = key_norm[127:64];
               key_in.key_len = len_sat;
               key_in.value   = req_ch.new_value;
               if (req_ch.req_type == REQ_UNBIND) begin
                  cache_in = NIL_PTR;
               end
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            bkt_in     = hash;
            head_raddr = hash;
            node_raddr = cache_ff[NODE_W-1:0];
            state_in   = ST_HEAD;
         end
         ST_HEAD: begin
            prev_in = NIL_PTR;
            cur_in  = head_rdata;
            priority if (type_ff != REQ_BIND && type_ff != REQ_RESOLVE &&
                         type_ff != REQ_UNBIND) begin
               res_stat_in = STAT_MISS;
               res_val_in  = '0;
               state_in    = ST_OUT;
            end else if (type_ff == REQ_RESOLVE && !cache_ff[NODE_W] && node_hit) begin
               res_stat_in = STAT_OK;
               res_val_in  = node_rdata.value;
               state_in    = ST_OUT;
            end else if (!head_rdata[NODE_W]) begin
               node_raddr = head_rdata[NODE_W-1:0];
               state_in   = ST_WALK;
            end else if (type_ff == REQ_BIND && !free_ff[NODE_W]) begin
               node_raddr = free_ff[NODE_W-1:0];
               state_in   = ST_ALLOC;
            end else begin
               res_stat_in = (type_ff == REQ_BIND) ? STAT_NOMEM : STAT_MISS;
               res_val_in  = '0;
               state_in    = ST_OUT;
            end
         end
         ST_WALK: begin
            if (node_hit) begin
               res_val_in  = node_rdata.value;
               res_stat_in = STAT_OK;
               state_in    = ST_OUT;
               if (type_ff == REQ_BIND) begin
                  res_stat_in = (node_rdata.value == key_ff.value) ? STAT_OK : STAT_BOUND;
               end else if (type_ff == REQ_RESOLVE) begin
                  cache_in = cur_ff;
               end else begin
                  // unlink: predecessor or bucket head takes the successor
                  if (!prev_ff[NODE_W]) begin
                     link_we    = 1'b1;
                     link_waddr = prev_ff[NODE_W-1:0];
                     link_wdata = link_rdata;
                  end else begin
                     head_we    = 1'b1;
                     head_wdata = link_rdata;
                  end
                  state_in = ST_UNL;
               end
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rdata;
               if (!link_rdata[NODE_W]) begin
                  node_raddr = link_rdata[NODE_W-1:0];
               end else if (type_ff == REQ_BIND && !free_ff[NODE_W]) begin
                  node_raddr = free_ff[NODE_W-1:0];
                  state_in   = ST_ALLOC;
               end else begin
                  res_stat_in = (type_ff == REQ_BIND) ? STAT_NOMEM : STAT_MISS;
                  res_val_in  = '0;
                  state_in    = ST_OUT;
               end
            end
         end
         ST_ALLOC: begin
            // link_rdata holds the successor of the free head
            free_in    = link_rdata;
            node_we    = 1'b1;
            link_we    = 1'b1;
            link_waddr = free_ff[NODE_W-1:0];
            link_wdata = NIL_PTR;
            cache_in   = free_ff;
            cur_in     = free_ff;
            state_in   = ST_LINK;
         end
         ST_LINK: begin
            if (!prev_ff[NODE_W]) begin
               link_we    = 1'b1;
               link_wdata = cur_ff;
            end else begin
               head_we    = 1'b1;
               head_wdata = cur_ff;
            end
            res_stat_in = STAT_OK;
            res_val_in  = key_ff.value;
            state_in    = ST_OUT;
         end
         ST_UNL: begin
            link_we    = 1'b1;
            link_waddr = cur_ff[NODE_W-1:0];
            link_wdata = free_ff;
            free_in    = cur_ff;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_val_in   = rsp_val_ff;
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_valid_in = 1'b1;
         rsp_stat_in  = res_stat_ff;
         rsp_val_in   = res_val_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         log2_ff      <= LOG2_RST;
         free_ff      <= '0;
         cache_ff     <= NIL_PTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         cache_ff     <= cache_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            log2_ff <= csr_wdata;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      key_ff      <= key_in;
      bkt_ff      <= bkt_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      res_stat_ff <= res_stat_in;
      res_val_ff  <= res_val_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_val_ff  <= rsp_val_in;
   end

   // checks
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) |-> !req_ch.ready)
      else $error("request taken during clearing pass");

   a_cache_ptr: assert property (@(posedge clock) disable iff (reset)
      cache_ff <= NIL_PTR)
      else $error("cache pointer out of range");

   a_free_ptr: assert property (@(posedge clock) disable iff (reset)
      free_ff <= NIL_PTR)
      else $error("free list pointer out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_HASH))
      else $error("accepted request not started");

   a_unbind_clears_cache: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.req_type == REQ_UNBIND) |=> (cache_ff == NIL_PTR))
      else $error("unbind left the cache set");
endmodule
